FILE: sv/x256pp_pkg.sv
// Shared types, constants and helpers for the xoshiro256++ five-way draw block.
// No dependencies; imported by every module of the block.
package x256pp_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned NUM_SEED = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned BUCKET_W = 3;
    localparam int unsigned HIST_SHIFT = 8;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 136;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_SEED-1:0][WORD_W-1:0] t_seed_set;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [BUCKET_W-1:0] t_bucket;

    // Register indexes on the configuration channel
    localparam t_cfg_idx REG_SEED_0 = 2'd0;
    localparam t_cfg_idx REG_SEED_1 = 2'd1;
    localparam t_cfg_idx REG_SEED_2 = 2'd2;
    localparam t_cfg_idx REG_SEED_3 = 2'd3;

    // Seed reset values
    localparam t_word SEED_RST_0 = 64'd599069558410000471;
    localparam t_word SEED_RST_1 = 64'd6334593251367909448;
    localparam t_word SEED_RST_2 = 64'd13763014985042389641;
    localparam t_word SEED_RST_3 = 64'd5577877247334134733;

    // Upper bounds (inclusive) of the first four fifths of the range
    localparam t_word FIFTH_1 = 64'd3689348814741910323;
    localparam t_word FIFTH_2 = 64'd7378697629483820646;
    localparam t_word FIFTH_3 = 64'd11068046444225730969;
    localparam t_word FIFTH_4 = 64'd14757395258967641292;

    // Bucket codes
    localparam t_bucket BKT_1 = 3'd1;
    localparam t_bucket BKT_2 = 3'd2;
    localparam t_bucket BKT_3 = 3'd3;
    localparam t_bucket BKT_4 = 3'd4;
    localparam t_bucket BKT_5 = 3'd5;

    // Generator step constants
    localparam int unsigned OUT_ROT   = 23;
    localparam int unsigned MIX_SHIFT = 17;
    localparam int unsigned S3_ROT    = 45;

    function automatic t_word rotl64(input t_word v, input int unsigned k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

endpackage

FILE: sv/x256pp_cfg.sv
// Seed register file written over the configuration channel.
// Depends on x256pp_pkg.
module x256pp_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  x256pp_pkg::t_cfg_idx  i_cfg_index,
    input  x256pp_pkg::t_word     i_cfg_data,
    output x256pp_pkg::t_seed_set o_seeds
);
    import x256pp_pkg::*;

    t_seed_set r_seeds;

    assign o_cfg_ready = 1'b1;
    assign o_seeds     = r_seeds;

    // One seed word per write beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeds[REG_SEED_0] <= SEED_RST_0;
            r_seeds[REG_SEED_1] <= SEED_RST_1;
            r_seeds[REG_SEED_2] <= SEED_RST_2;
            r_seeds[REG_SEED_3] <= SEED_RST_3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SEED_0: r_seeds[REG_SEED_0] <= i_cfg_data;
                REG_SEED_1: r_seeds[REG_SEED_1] <= i_cfg_data;
                REG_SEED_2: r_seeds[REG_SEED_2] <= i_cfg_data;
                REG_SEED_3: r_seeds[REG_SEED_3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/x256pp_gen.sv
// Generator state, state step and two-stage output computation.
// Depends on x256pp_pkg.
module x256pp_gen (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  x256pp_pkg::t_seed_set i_seeds,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_reload,
    output logic                  o_valid,
    input  logic                  i_ready,
    output x256pp_pkg::t_word     o_value
);
    import x256pp_pkg::*;

    t_word r_s0, r_s1, r_s2, r_s3;
    t_word s0, s1, s2, s3;
    t_word s2a, s3a;
    t_word n_s0, n_s1, n_s2, n_s3;
    t_word r_sum, r_base, r_value;
    logic  r_v1, r_v2;
    logic  st2_ready, accept;

    // Flow control: each stage moves when the one after it is free or moving
    assign st2_ready = !r_v2 || i_ready;
    assign o_ready   = !r_v1 || st2_ready;
    assign accept    = i_valid && o_ready;

    // Optional reload, then the published state step
    always_comb begin
        s0 = i_reload ? i_seeds[0] : r_s0;
        s1 = i_reload ? i_seeds[1] : r_s1;
        s2 = i_reload ? i_seeds[2] : r_s2;
        s3 = i_reload ? i_seeds[3] : r_s3;
        s2a  = s2 ^ s0;
        s3a  = s3 ^ s1;
        n_s1 = s1 ^ s2a;
        n_s0 = s0 ^ s3a;
        n_s2 = s2a ^ (s1 << MIX_SHIFT);
        n_s3 = rotl64(s3a, S3_ROT);
    end

    // State words advance once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= SEED_RST_0;
            r_s1 <= SEED_RST_1;
            r_s2 <= SEED_RST_2;
            r_s3 <= SEED_RST_3;
        end else if (accept) begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    // Stage 1: s0 + s3 of the pre-step state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum  <= s0 + s3;
            r_base <= s0;
        end
    end

    // Stage 2: rotate and final add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (st2_ready) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st2_ready && r_v1) begin
            r_value <= rotl64(r_sum, OUT_ROT) + r_base;
        end
    end

    assign o_valid = r_v2;
    assign o_value = r_value;

`ifndef NO_ASSERTIONS
    a_st2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_ready) |=> (r_v2 && $stable(r_value)))
        else $error("stage 2 result changed while stalled");
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && !i_ready) |-> !o_ready)
        else $error("input taken with both stages blocked");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ($stable(r_s0) && $stable(r_s3)))
        else $error("generator state moved without an accepted beat");
`endif

endmodule

FILE: sv/x256pp_bkt.sv
// Bucket classification, bucket history and the output register.
// Depends on x256pp_pkg.
module x256pp_bkt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  x256pp_pkg::t_word    i_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output x256pp_pkg::t_word    o_value,
    output x256pp_pkg::t_bucket  o_bucket,
    output x256pp_pkg::t_word    o_history
);
    import x256pp_pkg::*;

    t_bucket bkt;
    t_word   r_value, r_hist;
    t_bucket r_bucket;
    logic    r_v, load;

    assign o_ready = !r_v || i_ready;
    assign load    = i_valid && o_ready;

    // Fifth of the range; a value on a boundary goes to the lower bucket
    always_comb begin
        if (i_value <= FIFTH_1)      bkt = BKT_1;
        else if (i_value <= FIFTH_2) bkt = BKT_2;
        else if (i_value <= FIFTH_3) bkt = BKT_3;
        else if (i_value <= FIFTH_4) bkt = BKT_4;
        else                         bkt = BKT_5;
    end

    // History shifts one byte per delivered draw
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_hist <= '0;
        end else begin
            if (o_ready) r_v <= i_valid;
            if (load) begin
                r_hist <= {r_hist[WORD_W-HIST_SHIFT-1:0],
                           {(HIST_SHIFT-BUCKET_W){1'b0}}, bkt};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value  <= i_value;
            r_bucket <= bkt;
        end
    end

    assign o_valid   = r_v;
    assign o_value   = r_value;
    assign o_bucket  = r_bucket;
    assign o_history = r_hist;

`ifndef NO_ASSERTIONS
    a_bkt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_bucket == BKT_1 || r_bucket == BKT_2 || r_bucket == BKT_3
                 || r_bucket == BKT_4 || r_bucket == BKT_5))
        else $error("bucket out of range");
    a_hist_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_hist[HIST_SHIFT-1:0] == {{(HIST_SHIFT-BUCKET_W){1'b0}}, r_bucket}))
        else $error("history low byte differs from bucket");
    a_hist_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && !i_ready) |=> $stable(r_hist))
        else $error("history moved while output stalled");
`endif

endmodule

FILE: sv/xoshiro256pp_five_way_draw.sv
// Top level of the xoshiro256++ five-way draw block.
// Depends on x256pp_pkg, x256pp_cfg, x256pp_gen and x256pp_bkt.
//
// Each input beat draws one 64-bit xoshiro256++ value, sorts it into one of
// five equal fifths of the range (bucket 1..5) and shifts the bucket into a
// 64-bit history word, one byte per draw, newest in the lowest byte.
// Input stream: s_axis_tdata[0] = reload; when set, the seed registers are
// copied into the generator state before the draw.
// Output stream: one beat per input beat, in order.
// Config channel: i_cfg_index selects seed word 0..3, written on
// i_cfg_valid (always ready). Write only while the block is idle.
// Pipeline: sum stage, rotate/add stage, bucket/output register. Throughput:
// one beat per cycle while the output is not stalled; the state
// step is a single xor/rotate level done at acceptance.
// Reset: seeds and state take their default seeds, history clears, no beats
// in flight. A stall on m_axis_tready holds the output and backs up through
// the two internal stages; input is refused only when all three are full.
module xoshiro256pp_five_way_draw (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  x256pp_pkg::t_cfg_idx               i_cfg_index,
    input  x256pp_pkg::t_word                  i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] reload_seed, [7:1] zero
    input  logic [x256pp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [63:0] random_value, [66:64] bucket, [130:67] packed_buckets, [135:131] zero
    output logic [x256pp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import x256pp_pkg::*;

    t_seed_set seeds;
    logic      gen_valid, gen_ready;
    t_word     gen_value;
    t_word     out_value, out_hist;
    t_bucket   out_bucket;

    x256pp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_seeds     (seeds)
    );

    x256pp_gen u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seeds  (seeds),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_reload (s_axis_tdata[0]),
        .o_valid  (gen_valid),
        .i_ready  (gen_ready),
        .o_value  (gen_value)
    );

    x256pp_bkt u_bkt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (gen_valid),
        .o_ready   (gen_ready),
        .i_value   (gen_value),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (out_value),
        .o_bucket  (out_bucket),
        .o_history (out_hist)
    );

    // Pack result fields, lowest field first
    assign m_axis_tdata = {{(OUT_DATA_W-2*WORD_W-BUCKET_W){1'b0}},
                           out_hist, out_bucket, out_value};

endmodule
